>>> hw/rtl/mss_pkg.sv
// shared types and constants for the multi-separator stream splitter
// no dependencies; used by every other file of the block
package mss_pkg;

    localparam int NUM_PATTERN_REGS = 4;
    localparam int PATTERN_W        = 64;
    localparam int LEN_W            = 4;
    localparam int SEG_W            = 16;
    localparam int CFG_IDX_W        = 3;

    localparam logic [PATTERN_W-1:0] PATTERN_0_RESET = 64'd10;
    localparam logic [15:0]          LENGTHS_RESET   = 16'd1;
    localparam logic [SEG_W-1:0]     LIMIT_RESET     = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0 = 3'd0,
        CFG_PATTERN_1 = 3'd1,
        CFG_PATTERN_2 = 3'd2,
        CFG_PATTERN_3 = 3'd3,
        CFG_LENGTHS   = 3'd4,
        CFG_LIMIT     = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } item_t;

    // decoded configuration handed to the sequencer
    typedef struct packed {
        logic [NUM_PATTERN_REGS-1:0][PATTERN_W-1:0] pattern;
        logic [NUM_PATTERN_REGS-1:0][LEN_W-1:0]     sep_len;
        logic [LEN_W-1:0]                           depth;
        logic [SEG_W-1:0]                           seg_limit;
    } cfg_t;

endpackage

>>> hw/rtl/mss_if.sv
// channel interfaces: input bytes, result items, configuration writes
// depends on mss_pkg for field widths
interface mss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface mss_out_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [7:0]              out_byte;
    logic [mss_pkg::SEG_W-1:0] segment_number;
    logic                    run_end;

    modport source (output valid, output kind, output out_byte, output segment_number,
                    output run_end, input ready);
    modport sink   (input valid, input kind, input out_byte, input segment_number,
                    input run_end, output ready);
endinterface

interface mss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mss_pkg::CFG_IDX_W-1:0] index;
    logic [mss_pkg::PATTERN_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/multi_separator_stream_splitter_top.sv
// path: an item is registered in the queue, the sequencer loads it into the window
// and then writes its first result to the output register
// throughput: the sequencer loads each item, then produces one result per cycle
// while the output register is free; an item without results is only loaded there
// reset: rst_n clears queue, sequencer and stream state, config to its reset values
// window bytes are not reset; the block accepts items as soon as reset is released
module multi_separator_stream_splitter_top #(
    parameter int NUM_SEPARATORS    = 4,
    parameter int MAX_SEPARATOR_LEN = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    mss_in_if.sink    byte_ch,
    mss_out_if.source result_ch,
    mss_cfg_if.sink   cfg_ch
);
    import mss_pkg::*;

    // queue side of the front end
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    // decoded separators, depth and segment limit
    cfg_t  cfg;

    // front: takes bytes whenever the two-entry queue has room, so the
    // input side keeps moving while the back end works on an earlier item
    mss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    // configuration registers; always ready; to be written only while idle, which the block does not enforce
    mss_cfg #(
        .NUM_SEPARATORS    (NUM_SEPARATORS),
        .MAX_SEPARATOR_LEN (MAX_SEPARATOR_LEN)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    // back: appends the byte to the window, then steps the separator check
    // while the window holds the configured depth (or drains at end of stream), one
    // result per cycle while the output register that decouples the sink is free
    mss_back #(
        .MAX_SEPARATOR_LEN (MAX_SEPARATOR_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .result_ch (result_ch)
    );

endmodule

>>> hw/rtl/mss_front.sv
// front end: accepts input items into a two-entry queue
// depends on mss_pkg and mss_if
module mss_front (
    input  logic           clk,
    input  logic           rst_n,
    mss_in_if.sink         byte_ch,
    output logic           q_valid,
    output mss_pkg::item_t q_item,
    input  logic           q_pop
);
    import mss_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    item_t      entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign byte_ch.ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push          = byte_ch.valid && byte_ch.ready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{data_byte: byte_ch.data_byte,
                                       end_of_stream: byte_ch.end_of_stream};
        end
    end

endmodule

>>> hw/rtl/mss_cfg.sv
// configuration registers and decode of separator lengths and window depth
// depends on mss_pkg and mss_if
module mss_cfg #(
    parameter int NUM_SEPARATORS    = 4,
    parameter int MAX_SEPARATOR_LEN = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    mss_cfg_if.sink       cfg_ch,
    output mss_pkg::cfg_t cfg
);
    import mss_pkg::*;

    logic [NUM_PATTERN_REGS-1:0][PATTERN_W-1:0] pattern_reg;
    logic [15:0]                                lengths_reg;
    logic [SEG_W-1:0]                           limit_reg;
    logic                                       wr;

    assign cfg_ch.ready = 1'b1;
    assign wr           = cfg_ch.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // pattern 0 sits in the low bits, the others reset to zero
            pattern_reg    <= (NUM_PATTERN_REGS*PATTERN_W)'(PATTERN_0_RESET);
            lengths_reg    <= LENGTHS_RESET;
            limit_reg      <= LIMIT_RESET;
        end
        else if (wr)
        begin
            unique case (cfg_idx_t'(cfg_ch.index))
                CFG_PATTERN_0: pattern_reg[0] <= cfg_ch.data;
                CFG_PATTERN_1: pattern_reg[1] <= cfg_ch.data;
                CFG_PATTERN_2: pattern_reg[2] <= cfg_ch.data;
                CFG_PATTERN_3: pattern_reg[3] <= cfg_ch.data;
                CFG_LENGTHS:   lengths_reg    <= cfg_ch.data[15:0];
                CFG_LIMIT:     limit_reg      <= cfg_ch.data[SEG_W-1:0];
                default:       ;
            endcase
        end
    end

    // saturate lengths, drop separators beyond the configured count, derive the depth
    always_comb
    begin
        logic [LEN_W-1:0] raw;
        cfg.pattern   = pattern_reg;
        cfg.seg_limit = limit_reg;
        cfg.depth     = LEN_W'(1);
        for (int i = 0; i < NUM_PATTERN_REGS; i++)
        begin
            raw = lengths_reg[LEN_W*i +: LEN_W];
            if (i >= NUM_SEPARATORS)
                cfg.sep_len[i] = '0;
            else if (raw > LEN_W'(MAX_SEPARATOR_LEN))
                cfg.sep_len[i] = LEN_W'(MAX_SEPARATOR_LEN);
            else
                cfg.sep_len[i] = raw;
            if (cfg.sep_len[i] > cfg.depth)
                cfg.depth = cfg.sep_len[i];
        end
    end

endmodule

>>> hw/rtl/mss_back.sv
// back end: look-ahead window, separator match and result sequencer
// depends on mss_pkg and mss_if
module mss_back #(
    parameter int MAX_SEPARATOR_LEN = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mss_pkg::item_t q_item,
    output logic           q_pop,
    input  mss_pkg::cfg_t  cfg,
    mss_out_if.source      result_ch
);
    import mss_pkg::*;

    localparam int FILL_W = $clog2(MAX_SEPARATOR_LEN + 1);

    state_t                             state_reg, state_next;
    logic [MAX_SEPARATOR_LEN-1:0][7:0]  window_reg, window_next;
    logic [FILL_W-1:0]                  fill_reg, fill_next;
    logic                               seg_open_reg, seg_open_next;
    logic [SEG_W-1:0]                   seg_cnt_reg, seg_cnt_next;
    logic                               halted_reg, halted_next;
    logic                               eos_reg, eos_next;

    logic                               out_valid_reg, out_valid_next;
    kind_t                              kind_reg, kind_next;
    logic [7:0]                         byte_reg, byte_next;
    logic [SEG_W-1:0]                   seg_num_reg, seg_num_next;
    logic                               run_end_reg, run_end_next;

    logic                               hit_any;
    logic [LEN_W-1:0]                   hit_len;
    logic [SEG_W-1:0]                   seg_inc;
    logic                               over_limit;
    logic                               go_data;
    logic                               halt_now;
    logic [LEN_W-1:0]                   consume_cnt;
    logic [FILL_W-1:0]                  fill_after;
    logic [FILL_W-1:0]                  fill_app;
    logic                               more;
    logic                               last;
    logic                               start_step;
    logic                               slot_free;
    logic                               emit;

    // match, consume and continue decisions
    always_comb
    begin
        logic sep_hit;
        hit_any = 1'b0;
        hit_len = '0;
        for (int i = NUM_PATTERN_REGS - 1; i >= 0; i--)
        begin
            sep_hit = (cfg.sep_len[i] != '0) && (cfg.sep_len[i] <= LEN_W'(fill_reg));
            for (int j = 0; j < MAX_SEPARATOR_LEN; j++)
            begin
                if ((LEN_W'(j) < cfg.sep_len[i]) &&
                    (cfg.pattern[i][8*j +: 8] != window_reg[j]))
                    sep_hit = 1'b0;
            end
            if (sep_hit)
            begin
                hit_any = 1'b1;
                hit_len = cfg.sep_len[i];
            end
        end

        seg_inc    = seg_cnt_reg + SEG_W'(1);
        over_limit = (seg_inc >= cfg.seg_limit);
        go_data    = (state_reg == ST_STEP) && !hit_any && !seg_open_reg && !over_limit;
        halt_now   = (state_reg == ST_STEP) && (hit_any || !seg_open_reg) && over_limit;

        unique case (state_reg)
            ST_STEP: consume_cnt = hit_any ? hit_len : LEN_W'(seg_open_reg);
            ST_DATA: consume_cnt = LEN_W'(1);
            default: consume_cnt = '0;
        endcase

        fill_after = fill_reg - FILL_W'(consume_cnt);
        more       = !halt_now && (fill_after != '0) &&
                     (eos_reg || (LEN_W'(fill_after) >= cfg.depth));
        last       = !go_data && !more;

        fill_app   = (fill_reg < FILL_W'(MAX_SEPARATOR_LEN)) ? fill_reg + FILL_W'(1)
                                                              : fill_reg;
        start_step = q_item.end_of_stream || (LEN_W'(fill_app) >= cfg.depth);

        slot_free  = !out_valid_reg || result_ch.ready;
        emit       = ((state_reg == ST_STEP) || (state_reg == ST_DATA)) && slot_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && !halted_reg && start_step)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (emit)
                    state_next = go_data ? ST_DATA : (last ? ST_IDLE : ST_STEP);
            end
            ST_DATA:
            begin
                if (emit)
                    state_next = last ? ST_IDLE : ST_STEP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates and result payload
    always_comb
    begin
        q_pop          = 1'b0;
        window_next    = window_reg;
        fill_next      = fill_reg;
        seg_open_next  = seg_open_reg;
        seg_cnt_next   = seg_cnt_reg;
        halted_next    = halted_reg;
        eos_next       = eos_reg;
        out_valid_next = result_ch.ready ? 1'b0 : out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        seg_num_next   = seg_num_reg;
        run_end_next   = run_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    if (halted_reg)
                    begin
                        if (q_item.end_of_stream)
                        begin
                            fill_next     = '0;
                            seg_open_next = 1'b0;
                            seg_cnt_next  = '0;
                            halted_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        for (int j = 0; j < MAX_SEPARATOR_LEN; j++)
                        begin
                            if (fill_reg == FILL_W'(j))
                                window_next[j] = q_item.data_byte;
                        end
                        fill_next = fill_app;
                        eos_next  = q_item.end_of_stream;
                    end
                end
            end
            ST_STEP, ST_DATA:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    run_end_next   = last;
                    window_next    = window_reg >> {consume_cnt, 3'b000};
                    fill_next      = fill_after;
                    if ((state_reg == ST_STEP) && (hit_any || !seg_open_reg))
                    begin
                        // close any open segment and open the next one, or report an error at the limit
                        seg_cnt_next = seg_inc;
                        byte_next    = 8'd0;
                        seg_num_next = seg_inc;
                        if (over_limit)
                        begin
                            kind_next     = KIND_ERROR;
                            halted_next   = 1'b1;
                            seg_open_next = 1'b0;
                        end
                        else
                        begin
                            kind_next     = KIND_OPEN;
                            seg_open_next = 1'b1;
                        end
                    end
                    else
                    begin
                        kind_next    = KIND_DATA;
                        byte_next    = window_reg[0];
                        seg_num_next = seg_cnt_reg;
                    end
                    if (last && eos_reg)
                    begin
                        fill_next     = '0;
                        seg_open_next = 1'b0;
                        seg_cnt_next  = '0;
                        halted_next   = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            seg_open_reg  <= 1'b0;
            seg_cnt_reg   <= '0;
            halted_reg    <= 1'b0;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            seg_open_reg  <= seg_open_next;
            seg_cnt_reg   <= seg_cnt_next;
            halted_reg    <= halted_next;
            eos_reg       <= eos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg  <= window_next;
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
        seg_num_reg <= seg_num_next;
        run_end_reg <= run_end_next;
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.kind           = kind_reg;
    assign result_ch.out_byte       = byte_reg;
    assign result_ch.segment_number = seg_num_reg;
    assign result_ch.run_end        = run_end_reg;

endmodule

>>> hw/rtl/mss_checker.sv
// port-level checks on the result channel of the splitter
// depends on mss_pkg; bound to multi_separator_stream_splitter_top
module mss_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                kind,
    input logic [7:0]                out_byte,
    input logic [mss_pkg::SEG_W-1:0] segment_number,
    input logic                      run_end
);
    import mss_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // only data items carry a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_DATA) |-> (out_byte == 8'd0))
        else $error("non-data item with nonzero byte");

    // an error always ends the run of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR) |-> run_end)
        else $error("error item not marked as run end");

    // segment numbers count from one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (segment_number != '0))
        else $error("zero segment number");

endmodule

bind multi_separator_stream_splitter_top mss_checker u_mss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .kind           (result_ch.kind),
    .out_byte       (result_ch.out_byte),
    .segment_number (result_ch.segment_number),
    .run_end        (result_ch.run_end)
);

>>> verif/multi_separator_stream_splitter_top_tb.sv
// self-checking testbench for multi_separator_stream_splitter_top
// depends on mss_pkg and the channel interfaces in mss_if.sv
// a built-in predictor computes the expected results; directed tests run first, then random phases
`timescale 1ns / 1ps

module multi_separator_stream_splitter_top_tb;
    import mss_pkg::*;

    localparam int MAX_LEN         = 8;
    localparam int NUM_SEP         = 4;
    // cycles the block may still spend on items that cause no result
    localparam int SETTLE_CYCLES   = 64;
    localparam int WATCHDOG_CYCLES = 4000;

    // one result item as the output channel carries it
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] seg;
        logic        run_end;
    } split_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mss_in_if  byte_ch ();
    mss_out_if result_ch ();
    mss_cfg_if cfg_ch ();

    multi_separator_stream_splitter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idling control, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures       = 0;
    int quiet_cycles   = 0;

    // results still owed by the block, oldest first
    split_result_t pending_results[$];

    // mirror of the configuration registers
    logic [63:0] sep_pattern [NUM_SEP];
    logic [15:0] sep_lengths;
    logic [15:0] seg_limit;

    // mirror of the stream state
    logic [7:0]  win [MAX_LEN];
    int unsigned win_fill;
    bit          seg_open;
    int unsigned seg_count;
    bit          stream_halted;

    // ------------------------------------------------------------------
    // splitter predictor
    // ------------------------------------------------------------------

    // length of separator i, lengths above the window size saturate
    function automatic int unsigned sep_length(int i);
        logic [3:0] l;
        l = sep_lengths[4*i +: 4];
        return (l > MAX_LEN) ? MAX_LEN : l;
    endfunction

    // drop k bytes from the front of the window
    function automatic void drop_front(int unsigned k);
        if (k > win_fill)
            k = win_fill;
        for (int j = 0; j + k < win_fill; j++)
            win[j] = win[j + k];
        win_fill -= k;
    endfunction

    function automatic void clear_stream();
        win_fill      = 0;
        seg_open      = 1'b0;
        seg_count     = 0;
        stream_halted = 1'b0;
    endfunction

    // work out the results of one accepted item and queue them
    function automatic void predict_item(logic [7:0] b, logic eos);
        split_result_t found[$];
        int unsigned   depth;
        int unsigned   l;
        bit            matched;
        bit            hit;
        // a halted stream drops bytes until its last item
        if (stream_halted)
        begin
            if (eos)
                clear_stream();
            return;
        end
        if (win_fill < MAX_LEN)
        begin
            win[win_fill] = b;
            win_fill++;
        end
        depth = 1;
        for (int i = 0; i < NUM_SEP; i++)
            if (sep_length(i) > depth)
                depth = sep_length(i);
        // full window, or draining after the last byte
        while (!stream_halted && win_fill > 0 && (eos || win_fill >= depth))
        begin
            matched = 1'b0;
            for (int i = 0; i < NUM_SEP && !matched; i++)
            begin
                l   = sep_length(i);
                hit = (l != 0 && l <= win_fill);
                for (int j = 0; j < l && hit; j++)
                    if (sep_pattern[i][8*j +: 8] != win[j])
                        hit = 1'b0;
                if (hit)
                begin
                    drop_front(l);
                    seg_open = 1'b0;
                    matched  = 1'b1;
                end
            end
            if (!seg_open)
            begin
                seg_count++;
                if (seg_count >= seg_limit)
                begin
                    found.push_back('{KIND_ERROR, 8'h00, 16'(seg_count), 1'b0});
                    stream_halted = 1'b1;
                end
                else
                begin
                    seg_open = 1'b1;
                    found.push_back('{KIND_OPEN, 8'h00, 16'(seg_count), 1'b0});
                end
            end
            if (!stream_halted && !matched)
            begin
                found.push_back('{KIND_DATA, win[0], 16'(seg_count), 1'b0});
                drop_front(1);
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].run_end = 1'b1;
        foreach (found[k])
            pending_results.push_back(found[k]);
        if (eos)
            clear_stream();
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls and checking
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid and ready are settled at the falling edge, the item moves at the next rise
    always @(negedge clk)
    begin : check_results
        split_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d out_byte %02h segment_number %0d",
                       result_ch.kind, result_ch.out_byte, result_ch.segment_number);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, result_ch.kind);
                    failures++;
                end
                if (result_ch.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h",
                           want.out_byte, result_ch.out_byte);
                    failures++;
                end
                if (result_ch.segment_number !== want.seg)
                begin
                    $error("segment_number: expected %0d, actual %0d",
                           want.seg, result_ch.segment_number);
                    failures++;
                end
                if (result_ch.run_end !== want.run_end)
                begin
                    $error("run_end: expected %0d, actual %0d",
                           want.run_end, result_ch.run_end);
                    failures++;
                end
            end
        end
    end

    // watchdog: ends the run after too many cycles without any handshake
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("multi_separator_stream_splitter_top test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // send one byte item, called at a rising edge, returns at the edge that accepts it
    task automatic send_item(input logic [7:0] b, input logic eos);
        if ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_stream <= eos;
        @(negedge clk);
        while (!byte_ch.ready)
            @(negedge clk);
        @(posedge clk);
        predict_item(b, eos);
    endtask

    // stop sending, wait for every owed result, then let items without results finish
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // write all six registers while the block is idle
    task automatic program_regs(input logic [63:0] p0, input logic [63:0] p1,
                                input logic [63:0] p2, input logic [63:0] p3,
                                input logic [15:0] lens, input logic [15:0] limit);
        logic [63:0] values [6];
        cfg_idx_t    idx;
        values = '{p0, p1, p2, p3, 64'(lens), 64'(limit)};
        wait_idle();
        idx = idx.first();
        do
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= values[idx];
            @(negedge clk);
            while (!cfg_ch.ready)
                @(negedge clk);
            @(posedge clk);
            case (idx)
                CFG_LENGTHS: sep_lengths = values[idx][15:0];
                CFG_LIMIT:   seg_limit   = values[idx][15:0];
                default:     sep_pattern[idx] = values[idx];
            endcase
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset configuration: newline splits, trailing newline gives an empty last segment
    task automatic test_reset_newline();
        send_item(8'h00, 1'b0);
        send_item(8'h0a, 1'b0);
        send_item(8'hff, 1'b1);
        send_item("a", 1'b0);
        send_item(8'h0a, 1'b1);
    endtask

    // overlapping separators in priority order, an over-long length saturates the window
    task automatic test_priority_saturation();
        // "ab", "a", all ones with length 15, "xyz"
        program_regs(64'h6261, 64'h61, 64'hffff_ffff_ffff_ffff, 64'h7a7978,
                     16'h3f12, 16'd100);
        send_item("a", 1'b0);
        send_item("b", 1'b0);
        send_item("c", 1'b0);
        send_item("a", 1'b0);
        send_item("x", 1'b0);
        send_item("y", 1'b0);
        send_item("z", 1'b1);
    endtask

    // all lengths zero: bytes pass straight through, a newline is plain data
    task automatic test_no_separator();
        program_regs(64'h0, 64'h0, 64'h0, 64'h0, 16'h0000, 16'd100);
        send_item("p", 1'b0);
        send_item(8'h0a, 1'b0);
        send_item("q", 1'b1);
    endtask

    // limit below two: the first open already fails, the rest is dropped
    task automatic test_limit_one();
        program_regs(64'h0a, 64'h0, 64'h0, 64'h0, 16'h0001, 16'd1);
        send_item("q", 1'b0);
        send_item("r", 1'b1);
    endtask

    // third segment hits the limit, halted bytes are dropped until end of stream
    task automatic test_halt_on_limit();
        program_regs(64'h0a, 64'h0, 64'h0, 64'h0, 16'h0001, 16'd3);
        send_item("a", 1'b0);
        send_item(8'h0a, 1'b0);
        send_item("b", 1'b0);
        send_item(8'h0a, 1'b0);
        send_item("c", 1'b0);
        send_item("d", 1'b1);
    endtask

    // window shrinks from three to one with two bytes still held
    task automatic test_depth_lowered();
        program_regs(64'h636261, 64'h0, 64'h0, 64'h0, 16'h0003, 16'd100);
        send_item("x", 1'b0);
        send_item("y", 1'b0);
        program_regs(64'h61, 64'h0, 64'h0, 64'h0, 16'h0001, 16'd100);
        send_item("z", 1'b1);
    endtask

    // random configuration and streams built mostly from separators and a few symbols
    task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                       input int item_goal);
        logic [7:0]  symbols [4];
        logic [63:0] pats [NUM_SEP];
        logic [3:0]  lens [NUM_SEP];
        logic [15:0] limit;
        logic [7:0]  stream[$];
        int          sent;
        int          stream_len;
        int          pick;
        int          sel;
        int          cut;
        foreach (symbols[k])
            symbols[k] = 8'($urandom_range(255));
        for (int i = 0; i < NUM_SEP; i++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                lens[i] = 4'd0;
            else if (pick == 1)
                lens[i] = 4'($urandom_range(9, 15));
            else if (pick < 4)
                lens[i] = 4'($urandom_range(4, 8));
            else
                lens[i] = 4'($urandom_range(1, 3));
            pats[i] = {$urandom, $urandom};
            for (int j = 0; j < lens[i] && j < MAX_LEN; j++)
                pats[i][8*j +: 8] = symbols[$urandom_range(3)];
        end
        pick = $urandom_range(9);
        if (pick == 0)
            limit = 16'd2;
        else if (pick == 1)
            limit = 16'hffff;
        else
            limit = 16'($urandom_range(4, 14));
        program_regs(pats[0], pats[1], pats[2], pats[3],
                     {lens[3], lens[2], lens[1], lens[0]}, limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_goal)
        begin
            stream.delete();
            stream_len = $urandom_range(1, 24);
            while (stream.size() < stream_len)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    // whole separator, cut short one time in four
                    sel = $urandom_range(NUM_SEP - 1);
                    cut = (lens[sel] > MAX_LEN) ? MAX_LEN : lens[sel];
                    if (cut == 0)
                        cut = 1;
                    if ($urandom_range(3) == 0)
                        cut = $urandom_range(1, cut);
                    for (int j = 0; j < cut; j++)
                        stream.push_back(pats[sel][8*j +: 8]);
                end
                else if (pick < 85)
                    stream.push_back(symbols[$urandom_range(3)]);
                else
                    stream.push_back(8'($urandom_range(255)));
            end
            foreach (stream[k])
            begin
                sent++;
                send_item(stream[k], k == stream.size() - 1);
            end
        end
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        // known values on every input from the start
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = 8'h00;
        byte_ch.end_of_stream = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_PATTERN_0;
        cfg_ch.data           = '0;

        // predictor at its reset values
        foreach (sep_pattern[k])
            sep_pattern[k] = 64'h0;
        sep_pattern[0] = PATTERN_0_RESET;
        sep_lengths    = LENGTHS_RESET;
        seg_limit      = LIMIT_RESET;
        foreach (win[k])
            win[k] = 8'h00;
        clear_stream();

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_newline();
        test_priority_saturation();
        test_no_separator();
        test_limit_one();
        test_halt_on_limit();
        test_depth_lowered();

        // no idling, sender idle, receiver stalling, both
        test_random_streams(0, 0, 85);
        test_random_streams(50, 0, 85);
        test_random_streams(0, 50, 85);
        test_random_streams(38, 38, 85);

        wait_idle();
        if (failures == 0)
            $display("multi_separator_stream_splitter_top test passed");
        else
            $display("multi_separator_stream_splitter_top test failed");
        $finish;
    end

endmodule
